// ===== sv/adc_window_zone_vote_debounce_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the zone vote debounce block
// Shared concurrent check forms, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef ADC_WINDOW_ZONE_VOTE_DEBOUNCE_TOP_ASSERT_SVH
`define ADC_WINDOW_ZONE_VOTE_DEBOUNCE_TOP_ASSERT_SVH

// Same-cycle implication: when cond holds, expr must hold too.
`define AWZVD_ASSERT_NOW(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// Next-cycle implication: when cond holds, expr must hold in the next cycle.
`define AWZVD_ASSERT_NEXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/awzvd_pkg.sv =====
// ----------------------------------------------------------------------------
// awzvd_pkg
// Types, codes and sizes shared by the zone vote debounce modules.
// ----------------------------------------------------------------------------
package awzvd_pkg;

  localparam int READS     = 3;
  localparam int NUM_ZONES = 5;
  localparam int CNT_W     = 4;
  localparam int ZONE_W    = 3;
  localparam int COUNTS_W  = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 32;

  typedef enum logic [2:0] {
    ST_NOT_YET       = 3'd0,
    ST_COLLECTING    = 3'd1,
    ST_DETECTED      = 3'd2,
    ST_UNKNOWN       = 3'd3,
    ST_TIMEOUT       = 3'd4,
    ST_RESTARTED     = 3'd5,
    ST_NEEDS_RESTART = 3'd6
  } status_t;

  localparam logic [ZONE_W-1:0] ZONE_NONE    = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_UNKNOWN = 3'd6;

  localparam logic [2:0] CFG_ABSENT_FLOOR   = 3'd0;
  localparam logic [2:0] CFG_ZONE_ONE       = 3'd1;
  localparam logic [2:0] CFG_ZONE_TWO       = 3'd2;
  localparam logic [2:0] CFG_ZONE_THREE     = 3'd3;
  localparam logic [2:0] CFG_ZONE_FOUR      = 3'd4;
  localparam logic [2:0] CFG_ZONE_FIVE      = 3'd5;
  localparam logic [2:0] CFG_READ_INTERVAL  = 3'd6;
  localparam logic [2:0] CFG_VOTE_THRESHOLD = 3'd7;

  // Window register layout: high bound in the upper half.
  typedef struct packed {
    logic [COUNTS_W-1:0] hi;
    logic [COUNTS_W-1:0] lo;
  } window_t;

  typedef struct packed {
    logic              win;
    logic [ZONE_W-1:0] zone;
    logic [CNT_W-1:0]  agree;
  } vote_t;

  typedef logic [ZONE_W-1:0] zone_code_t;

endpackage

// ===== sv/adc_window_zone_vote_debounce_top.sv =====
// ----------------------------------------------------------------------------
// adc_window_zone_vote_debounce_top
// Zone identification debounce: windowed ADC classification plus a vote.
// ----------------------------------------------------------------------------
// Each input transfer either restarts the debounce (tuser 0) or offers one ADC
// sample (tuser 1), and each produces exactly one result transfer. A sample is
// ignored (not yet time) until now_time reaches the stored next read time, a
// failed conversion reports a timeout, and otherwise the reading is classified
// (absent, zone 5 down to zone 1, else unknown) and stored while the next read
// time moves to now_time + read_interval. The third stored sample triggers
// the vote; later samples report that a restart is needed. The block takes one
// transfer per clock while the output is not stalled: the input register holds
// the sample already classified, and the state and result register update when
// it advances, so a result passes through the input register and then the
// result register. A stall on the output side holds the input register and
// drops s_tready, so it backs up into the input stream. Write the configuration
// registers only while no transfer is in flight.
// ----------------------------------------------------------------------------
`include "adc_window_zone_vote_debounce_top_assert.svh"

module adc_window_zone_vote_debounce_top
  import awzvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [55:0]       s_tdata,   // now_time[31:0], adc_counts[47:32], adc_ok[48]
  input  logic              s_tuser,   // action
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // zone[2:0], agree_count[6:3], reads_taken[10:7]
  output logic [2:0]        m_tuser    // status
);

  // configuration
  logic [COUNTS_W-1:0]     absent_floor;
  window_t [NUM_ZONES-1:0] windows;
  logic [COUNTS_W-1:0]     read_interval;
  logic [CNT_W-1:0]        vote_threshold;

  // debounce state
  logic [TIME_W-1:0]       next_read_time;
  logic [CNT_W-1:0]        stored_count;
  zone_code_t [READS-1:0]  history;

  // input register
  logic                    in_valid;
  logic                    in_action;
  logic [TIME_W-1:0]       in_now;
  logic                    in_ok;
  logic [ZONE_W-1:0]       in_zone;

  // result register
  logic                    out_valid;
  status_t                 out_status;
  logic [ZONE_W-1:0]       out_zone;
  logic [CNT_W-1:0]        out_agree;
  logic [CNT_W-1:0]        out_reads;

  logic                    s_xfer;
  logic                    advance;
  logic [ZONE_W-1:0]       sample_zone;

  // next values
  status_t                 status_next;
  logic [ZONE_W-1:0]       zone_next;
  logic [CNT_W-1:0]        agree_next;
  logic [CNT_W-1:0]        stored_count_next;
  logic                    take;
  logic                    restart;
  zone_code_t [READS-1:0]  vote_hist;
  vote_t                   vote;

  // Advance the item in the input register whenever the result slot is free
  // or being emptied this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_xfer   = s_tvalid && s_tready;

  // Classify on the way in; the user must keep configuration stable while items are in flight (not enforced).
  awzvd_classify u_classify (
    .counts       (s_tdata[47:32]),
    .absent_floor (absent_floor),
    .windows      (windows),
    .zone         (sample_zone)
  );

  // The vote sees the stored reads with the incoming one in the last slot; it
  // is used only when this sample completes the history.
  always_comb begin
    for (int i = 0; i < READS; i++) begin
      vote_hist[i] = (i == READS - 1) ? in_zone : history[i];
    end
  end

  awzvd_vote u_vote (
    .hist      (vote_hist),
    .threshold (vote_threshold),
    .vote      (vote)
  );

  always_comb begin
    status_next       = ST_NOT_YET;
    zone_next         = ZONE_NONE;
    agree_next        = '0;
    stored_count_next = stored_count;
    take              = 1'b0;
    restart           = 1'b0;
    priority if (!in_action) begin
      restart           = 1'b1;
      stored_count_next = '0;
      status_next       = ST_RESTARTED;
    end else if (stored_count >= CNT_W'(READS)) begin
      status_next = ST_NEEDS_RESTART;
    end else if (in_now < next_read_time) begin
      status_next = ST_NOT_YET;
    end else if (!in_ok) begin
      status_next = ST_TIMEOUT;
    end else begin
      take              = 1'b1;
      stored_count_next = stored_count + CNT_W'(1);
      if (stored_count_next < CNT_W'(READS)) begin
        status_next = ST_COLLECTING;
      end else if (vote.win) begin
        status_next = ST_DETECTED;
        zone_next   = vote.zone;
        agree_next  = vote.agree;
      end else begin
        status_next = ST_UNKNOWN;
        zone_next   = ZONE_UNKNOWN;
      end
    end
  end

  // Control, configuration and debounce state.
  always_ff @(posedge clk) begin
    if (rst) begin
      absent_floor   <= '1;
      windows        <= '0;
      read_interval  <= COUNTS_W'(100);
      vote_threshold <= CNT_W'(2);
      next_read_time <= '0;
      stored_count   <= '0;
      history        <= '0;
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ABSENT_FLOOR:   absent_floor   <= cfg_data[COUNTS_W-1:0];
          CFG_ZONE_ONE:       windows[0]     <= cfg_data;
          CFG_ZONE_TWO:       windows[1]     <= cfg_data;
          CFG_ZONE_THREE:     windows[2]     <= cfg_data;
          CFG_ZONE_FOUR:      windows[3]     <= cfg_data;
          CFG_ZONE_FIVE:      windows[4]     <= cfg_data;
          CFG_READ_INTERVAL:  read_interval  <= cfg_data[COUNTS_W-1:0];
          CFG_VOTE_THRESHOLD: vote_threshold <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (s_xfer) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid    <= 1'b1;
        stored_count <= stored_count_next;
        if (restart) begin
          history        <= '0;
          next_read_time <= in_now;
        end else if (take) begin
          next_read_time <= in_now + TIME_W'(read_interval);
          for (int i = 0; i < READS; i++) begin
            if (stored_count == CNT_W'(i)) begin
              history[i] <= in_zone;
            end
          end
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: load on an input transfer or an advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_action <= s_tuser;
      in_now    <= s_tdata[31:0];
      in_ok     <= s_tdata[48];
      in_zone   <= sample_zone;
    end
    if (advance) begin
      out_status <= status_next;
      out_zone   <= zone_next;
      out_agree  <= agree_next;
      out_reads  <= stored_count_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {5'b0, out_reads, out_agree, out_zone};

  // The stored count never runs past the history depth.
  `AWZVD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, stored_count <= CNT_W'(READS))
  // A restart leaves an empty history behind it.
  `AWZVD_ASSERT_NEXT(a_restart_clears, clk, rst, advance && !in_action, stored_count == '0)
  // A detection is only reported on a full history.
  `AWZVD_ASSERT_NOW(a_detect_full, clk, rst, out_valid && out_status == ST_DETECTED,
                    out_reads == CNT_W'(READS))
  // A restarted result always reports zero reads.
  `AWZVD_ASSERT_NOW(a_restart_reads, clk, rst, out_valid && out_status == ST_RESTARTED,
                    out_reads == '0)

endmodule

// ===== sv/awzvd_classify.sv =====
// ----------------------------------------------------------------------------
// awzvd_classify
// Map one ADC reading to a zone code through the priority-ordered windows.
// ----------------------------------------------------------------------------
module awzvd_classify
  import awzvd_pkg::*;
(
  input  logic [COUNTS_W-1:0]         counts,
  input  logic [COUNTS_W-1:0]         absent_floor,
  input  window_t [NUM_ZONES-1:0]     windows,
  output logic [ZONE_W-1:0]           zone
);

  always_comb begin
    zone = ZONE_UNKNOWN;
    // Ascending scan, later hits overwrite: zone 5 has the highest priority.
    for (int z = 1; z <= NUM_ZONES; z++) begin
      if (counts >= windows[z-1].lo && counts <= windows[z-1].hi) begin
        zone = ZONE_W'(z);
      end
    end
    if (counts >= absent_floor) begin
      zone = ZONE_NONE;
    end
  end

endmodule

// ===== sv/awzvd_vote.sv =====
// ----------------------------------------------------------------------------
// awzvd_vote
// Tally a full read history per zone and pick the lowest zone that meets
// the vote threshold.
// ----------------------------------------------------------------------------
module awzvd_vote
  import awzvd_pkg::*;
(
  input  zone_code_t [READS-1:0] hist,
  input  logic [CNT_W-1:0]       threshold,
  output vote_t                  vote
);

  logic [CNT_W-1:0] tally [NUM_ZONES];

  always_comb begin
    for (int z = 0; z < NUM_ZONES; z++) begin
      tally[z] = '0;
      for (int i = 0; i < READS; i++) begin
        if (hist[i] == ZONE_W'(z + 1)) begin
          tally[z] = tally[z] + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    vote = '0;
    // Scan downward so the lowest qualifying zone wins.
    for (int z = NUM_ZONES - 1; z >= 0; z--) begin
      if (tally[z] >= threshold) begin
        vote.win   = 1'b1;
        vote.zone  = ZONE_W'(z + 1);
        vote.agree = tally[z];
      end
    end
  end

endmodule
